/* rtl/csv_record_tokenizer_macros.svh */
// Assertion macros for the port-level tokenizer checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef CSV_RECORD_TOKENIZER_MACROS_SVH
`define CSV_RECORD_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CSVTOK_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("csv tokenizer check failed");

// Next-cycle implication, disabled while reset is high.
`define CSVTOK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("csv tokenizer check failed");

`endif

/* rtl/csvtok_pkg.sv */
// Shared types and constants for the CSV record tokenizer.
// No dependencies; imported by every tokenizer module.
`timescale 1ns / 1ps

package csvtok_pkg;

   // Special characters of the text format.
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Delimiter after reset is a comma.
   localparam logic [7:0] DELIM_RESET = 8'd44;

   // Event codes reported with each result.
   localparam logic [2:0] EV_SWALLOW    = 3'd0;
   localparam logic [2:0] EV_DATA       = 3'd1;
   localparam logic [2:0] EV_FIELD_END  = 3'd2;
   localparam logic [2:0] EV_RECORD_END = 3'd3;
   localparam logic [2:0] EV_ERROR      = 3'd4;
   localparam logic [2:0] EV_NO_MORE    = 3'd5;

   // Error codes.
   localparam logic ERR_STRAY_CHAR   = 1'b0;
   localparam logic ERR_UNTERMINATED = 1'b1;

   // Parser states, one-hot.
   typedef enum logic [5:0] {
      ST_REC_START   = 6'b000001,
      ST_FIELD_START = 6'b000010,
      ST_UNQUOTED    = 6'b000100,
      ST_QUOTED      = 6'b001000,
      ST_QUOTE_PEND  = 6'b010000,
      ST_CR_PEND     = 6'b100000
   } parse_state_type;

   // One input request.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   // One result.
   typedef struct packed {
      logic [2:0] event_kind;
      logic [7:0] field_char;
      logic       error_kind;
   } rsp_type;

endpackage

/* rtl/csvtok_decode.sv */
// Next-state and event logic of the tokenizer for one request.
// Depends on csvtok_pkg; purely combinational.
`timescale 1ns / 1ps

module csvtok_decode (
   input  csvtok_pkg::parse_state_type state,
   input  csvtok_pkg::req_type         req,
   input  logic [7:0]                  delimiter,
   output csvtok_pkg::parse_state_type state_next,
   output csvtok_pkg::rsp_type         rsp
);
   import csvtok_pkg::*;

   logic use_unquoted;
   logic at_field_start;
   logic after_close;
   logic is_quote;

   assign is_quote = (req.text_byte == CH_QUOTE);

   always_comb begin
      state_next     = ST_REC_START;
      rsp            = '0;
      use_unquoted   = 1'b0;
      at_field_start = 1'b0;
      after_close    = 1'b0;

      if (req.end_of_input) begin
         // End of input closes the open record or reports the end of the stream.
         case (state)
            ST_QUOTED: begin
               rsp.event_kind = EV_ERROR;
               rsp.error_kind = ERR_UNTERMINATED;
            end
            ST_FIELD_START, ST_UNQUOTED, ST_QUOTE_PEND: begin
               rsp.event_kind = EV_RECORD_END;
            end
            default: begin
               rsp.event_kind = EV_NO_MORE;
            end
         endcase
      end else begin
         // States that look at quotes and line ends before the common path.
         case (state)
            ST_QUOTED: begin
               if (is_quote) begin
                  state_next     = ST_QUOTE_PEND;
                  rsp.event_kind = EV_SWALLOW;
               end else begin
                  state_next     = ST_QUOTED;
                  rsp.event_kind = EV_DATA;
                  rsp.field_char = req.text_byte;
               end
            end
            ST_QUOTE_PEND: begin
               if (is_quote) begin
                  state_next     = ST_QUOTED;
                  rsp.event_kind = EV_DATA;
                  rsp.field_char = CH_QUOTE;
               end else begin
                  use_unquoted = 1'b1;
                  after_close  = 1'b1;
               end
            end
            ST_CR_PEND: begin
               if (req.text_byte == CH_LF) begin
                  state_next     = ST_REC_START;
                  rsp.event_kind = EV_SWALLOW;
               end else begin
                  use_unquoted   = 1'b1;
                  at_field_start = 1'b1;
               end
            end
            ST_UNQUOTED: begin
               use_unquoted = 1'b1;
            end
            default: begin
               // Record start, field start and unused codes.
               use_unquoted   = 1'b1;
               at_field_start = 1'b1;
            end
         endcase

         // Handling of a byte outside quotes.
         if (use_unquoted) begin
            if (req.text_byte == delimiter) begin
               state_next     = ST_FIELD_START;
               rsp.event_kind = EV_FIELD_END;
            end else if (req.text_byte == CH_LF || req.text_byte == CH_CR) begin
               state_next     = (req.text_byte == CH_CR) ? ST_CR_PEND : ST_REC_START;
               rsp.event_kind = EV_RECORD_END;
            end else if (is_quote && at_field_start) begin
               state_next     = ST_QUOTED;
               rsp.event_kind = EV_SWALLOW;
            end else if (is_quote || after_close) begin
               state_next     = ST_REC_START;
               rsp.event_kind = EV_ERROR;
               rsp.error_kind = ERR_STRAY_CHAR;
            end else begin
               state_next     = ST_UNQUOTED;
               rsp.event_kind = EV_DATA;
               rsp.field_char = req.text_byte;
            end
         end
      end
   end

endmodule

/* rtl/csv_record_tokenizer.sv */
// Top level of the CSV record tokenizer: input register, parser, result register.
// Depends on csvtok_pkg and csvtok_decode.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_valid / req_stall    req_data (text_byte, end_of_input)
//   rsp      out        rsp_valid / rsp_stall    rsp_data (event_kind, field_char, error_kind)
//   csr      in         csr_write_enable         csr_write_data (delimiter)
//
// One request per cycle is taken while req_stall is low; each result is registered in the input
// register and then in the result register around the parser.
// Reset is synchronous and empties both registers; the delimiter returns to a comma.
// A stalled result holds; the input side stalls only while both registers are full.
`timescale 1ns / 1ps

module csv_record_tokenizer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  csvtok_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output csvtok_pkg::rsp_type rsp_data,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data
);
   import csvtok_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff;
   logic            out_valid_ff, out_valid_in;
   rsp_type         out_data_ff;
   parse_state_type state_ff, state_in;
   logic [7:0]      delimiter_ff, delimiter_in;
   rsp_type         step_rsp;
   logic            req_accept;
   logic            advance;
   logic            delim_legal;

   // Handshake control between the two registers.
   assign advance     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && out_valid_ff && rsp_stall;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (out_valid_ff && rsp_stall);

   // Refused delimiter values leave the register unchanged.
   assign delim_legal = (csr_write_data != CH_NUL) && (csr_write_data != CH_QUOTE) &&
                        (csr_write_data != CH_CR) && (csr_write_data != CH_LF);
   assign delimiter_in = (csr_write_enable && delim_legal) ? csr_write_data : delimiter_ff;

   csvtok_decode u_decode (
      .state      (state_ff),
      .req        (in_data_ff),
      .delimiter  (delimiter_ff),
      .state_next (state_in),
      .rsp        (step_rsp)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_REC_START;
         delimiter_ff <= DELIM_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         delimiter_ff <= delimiter_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* rtl/csvtok_checker.sv */
// Port-level checks of the CSV record tokenizer, bound to the top level.
// Depends on csvtok_pkg and csv_record_tokenizer_macros.svh.
`timescale 1ns / 1ps

`include "csv_record_tokenizer_macros.svh"

module csvtok_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input csvtok_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input csvtok_pkg::rsp_type rsp_data
);
   import csvtok_pkg::*;

   logic req_accept;

   assign req_accept = req_valid && !req_stall && (req_data.end_of_input || 1'b1);

   // A stalled result stays valid and unchanged.
   `CSVTOK_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // A new result follows an accepted request through the input and result registers.
   `CSVTOK_ASSERT_IMPL(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_accept, 2))

   // Only data events carry a character.
   `CSVTOK_ASSERT_IMPL(a_char_only_data, clock, reset, rsp_valid && rsp_data.event_kind != EV_DATA, rsp_data.field_char == 8'd0)

   // The unterminated-field code appears only with an error event.
   `CSVTOK_ASSERT_IMPL(a_err_kind, clock, reset, rsp_valid && rsp_data.error_kind, rsp_data.event_kind == EV_ERROR)

endmodule

bind csv_record_tokenizer csvtok_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

/* dv/csv_record_tokenizer_checker.sv */
// Result checker for the CSV record tokenizer: tracks the delimiter register, predicts
// one event per accepted request and compares it with the result stream.
// Depends on csvtok_pkg for the channel payload types, event codes and parser states.
`timescale 1ns / 1ps

module csv_record_tokenizer_checker (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  csvtok_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  csvtok_pkg::rsp_type rsp_data,
   input  logic                csr_write_enable,
   input  logic [7:0]          csr_write_data,
   output int                  fail_count,
   output int                  outstanding
);
   import csvtok_pkg::*;

   parse_state_type tok_state;
   logic [7:0]      tok_delim;
   rsp_type         expected_events[$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
      tok_state   = ST_REC_START;
      tok_delim   = DELIM_RESET;
   end

   // One step of the tokenizer: the event for one request and the state after it.
   function automatic void tokenize_byte(input parse_state_type st_in,
                                         input logic [7:0] delim, input req_type r,
                                         output parse_state_type st_out,
                                         output rsp_type ev);
      logic [7:0] b;
      logic       closed;
      logic       at_start;
      b      = r.text_byte;
      ev     = '0;
      st_out = ST_REC_START;
      if (r.end_of_input) begin
         if (st_in == ST_REC_START || st_in == ST_CR_PEND) begin
            ev.event_kind = EV_NO_MORE;
         end else if (st_in == ST_QUOTED) begin
            ev.event_kind = EV_ERROR;
            ev.error_kind = ERR_UNTERMINATED;
         end else begin
            // A pending quote counts as the closing quote.
            ev.event_kind = EV_RECORD_END;
         end
      end else if (st_in == ST_QUOTED) begin
         if (b == CH_QUOTE) begin
            st_out        = ST_QUOTE_PEND;
            ev.event_kind = EV_SWALLOW;
         end else begin
            st_out        = ST_QUOTED;
            ev.event_kind = EV_DATA;
            ev.field_char = b;
         end
      end else if (st_in == ST_QUOTE_PEND && b == CH_QUOTE) begin
         // A doubled quote inside quotes is one literal quote.
         st_out        = ST_QUOTED;
         ev.event_kind = EV_DATA;
         ev.field_char = CH_QUOTE;
      end else if (st_in == ST_CR_PEND && b == CH_LF) begin
         ev.event_kind = EV_SWALLOW;
      end else begin
         // Outside quotes; a pending quote has closed its field.
         closed   = (st_in == ST_QUOTE_PEND);
         at_start = (st_in == ST_REC_START || st_in == ST_FIELD_START ||
                     st_in == ST_CR_PEND);
         if (b == delim) begin
            st_out        = ST_FIELD_START;
            ev.event_kind = EV_FIELD_END;
         end else if (b == CH_LF || b == CH_CR) begin
            st_out        = (b == CH_CR) ? ST_CR_PEND : ST_REC_START;
            ev.event_kind = EV_RECORD_END;
         end else if (b == CH_QUOTE && at_start) begin
            st_out        = ST_QUOTED;
            ev.event_kind = EV_SWALLOW;
         end else if (b == CH_QUOTE || closed) begin
            ev.event_kind = EV_ERROR;
            ev.error_kind = ERR_STRAY_CHAR;
         end else begin
            st_out        = ST_UNQUOTED;
            ev.event_kind = EV_DATA;
            ev.field_char = b;
         end
      end
   endfunction

   // Watch both channels and the register port at every rising edge.
   always @(posedge clock) begin : monitor
      parse_state_type next_state;
      rsp_type         want;
      if (reset) begin
         tok_state = ST_REC_START;
         tok_delim = DELIM_RESET;
         expected_events.delete();
      end else begin
         // Results are checked first, so one arriving with an empty queue is caught.
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("unexpected result: event_kind %0d, field_char %0d, error_kind %0d",
                      rsp_data.event_kind, rsp_data.field_char, rsp_data.error_kind);
               fail_count++;
            end else begin
               want = expected_events.pop_front();
               if (rsp_data.event_kind !== want.event_kind) begin
                  $error("event_kind: expected %0d, actual %0d",
                         want.event_kind, rsp_data.event_kind);
                  fail_count++;
               end
               if (rsp_data.field_char !== want.field_char) begin
                  $error("field_char: expected %0d, actual %0d",
                         want.field_char, rsp_data.field_char);
                  fail_count++;
               end
               if (rsp_data.error_kind !== want.error_kind) begin
                  $error("error_kind: expected %0d, actual %0d",
                         want.error_kind, rsp_data.error_kind);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            tokenize_byte(tok_state, tok_delim, req_data, next_state, want);
            tok_state = next_state;
            // Append the predicted event at the tail of the queue.
            expected_events = {expected_events, want};
         end
         // NUL, quote, CR and LF are refused as delimiters.
         if (csr_write_enable && csr_write_data != CH_NUL && csr_write_data != CH_QUOTE &&
             csr_write_data != CH_CR && csr_write_data != CH_LF) begin
            tok_delim = csr_write_data;
         end
      end
      outstanding = expected_events.size();
   end

endmodule

/* dv/csv_record_tokenizer_tb.sv */
// Testbench top for the CSV record tokenizer: clock, reset, request and register stimulus,
// a stalling result receiver and the final verdict.
// Depends on csvtok_pkg, csv_record_tokenizer and csv_record_tokenizer_checker.
`timescale 1ns / 1ps

module csv_record_tokenizer_tb;
   import csvtok_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int PHASES       = 10;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 300000;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;
   int         fail_count;
   int         outstanding;

   logic [7:0] delim_now;
   logic [7:0] phase_delims [PHASES];
   logic       hold_wanted;
   int         burst_left;
   int         requests_sent;
   int         phase_start;
   int         cycle_count;

   csv_record_tokenizer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   csv_record_tokenizer_checker tokenizer_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one request and hold it until accepted; bursts end with a random gap.
   task automatic send_request(input logic [7:0] b, input logic eoi);
      req_data.text_byte    = b;
      req_data.end_of_input = eoi;
      req_valid             = 1'b1;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      @(negedge clock);
      requests_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic wait_drained();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_delimiter(input logic [7:0] value);
      csr_write_enable = 1'b1;
      csr_write_data   = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (value != CH_NUL && value != CH_QUOTE && value != CH_CR && value != CH_LF)
         delim_now = value;
   endtask

   // A byte that is ordinary content outside quotes.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = CH_QUOTE;
      while (b == delim_now || b == CH_QUOTE || b == CH_CR || b == CH_LF)
         b = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(8'h20, 8'h7E))
                                         : 8'($urandom_range(0, 255));
      return b;
   endfunction

   // One record of random fields, now and then broken by a typical format error.
   task automatic send_record();
      int         nfields;
      int         len;
      int         kind;
      logic [7:0] b;
      nfields = $urandom_range(1, 5);
      for (int f = 0; f < nfields; f++) begin
         if (f > 0) send_request(delim_now, 1'b0);
         kind = $urandom_range(0, 9);
         if (kind >= 1 && kind <= 4) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) send_request(plain_byte(), 1'b0);
            if ($urandom_range(0, 15) == 0) begin
               // Quote in the middle of an unquoted field.
               send_request(CH_QUOTE, 1'b0);
               return;
            end
         end else if (kind >= 5) begin
            send_request(CH_QUOTE, 1'b0);
            len = $urandom_range(0, 6);
            for (int i = 0; i < len; i++) begin
               case ($urandom_range(0, 7))
                  0: begin
                     send_request(CH_QUOTE, 1'b0);
                     send_request(CH_QUOTE, 1'b0);
                  end
                  1: send_request(delim_now, 1'b0);
                  2: send_request(CH_CR, 1'b0);
                  3: send_request(CH_LF, 1'b0);
                  default: begin
                     b = 8'($urandom_range(0, 255));
                     if (b == CH_QUOTE) b = 8'h27;
                     send_request(b, 1'b0);
                  end
               endcase
            end
            if ($urandom_range(0, 19) == 0) begin
               // Input ends inside the quotes.
               send_request(8'($urandom_range(0, 255)), 1'b1);
               return;
            end
            send_request(CH_QUOTE, 1'b0);
            if ($urandom_range(0, 15) == 0) begin
               // Content right after the closing quote.
               send_request(plain_byte(), 1'b0);
               return;
            end
         end
      end
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            send_request(CH_CR, 1'b0);
            send_request(CH_LF, 1'b0);
         end
         3, 4, 5: send_request(CH_LF, 1'b0);
         6, 7:    send_request(CH_CR, 1'b0);
         default: send_request(8'($urandom_range(0, 255)), 1'b1);
      endcase
   endtask

   // Result receiver: stalls on modes of random length, plus one long hold-off on request.
   initial begin : receiver
      stall_mode_type mode;
      int             mode_left;
      int             hold_left;
      rsp_stall = 1'b0;
      mode      = STALL_NONE;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            hold_left   = HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 120);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall = 1'b1;
         end else begin
            case (mode)
               STALL_NONE:  rsp_stall = 1'b0;
               STALL_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
               STALL_HEAVY: rsp_stall = ($urandom_range(0, 3) != 0);
               default:     rsp_stall = ~rsp_stall;
            endcase
         end
      end
   end

   // Run limit.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Main sequence: reset, directed cases, then random phases under several delimiters.
   initial begin : stimulus
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      delim_now        = DELIM_RESET;
      hold_wanted      = 1'b0;
      burst_left       = 0;
      requests_sent    = 0;
      phase_delims     = '{8'h3B, 8'h00, 8'h09, 8'h22, 8'hFF, 8'h0D, 8'h01, 8'h0A,
                           8'h7C, 8'h2C};
      phase_delims[8]  = 8'($urandom_range(1, 255));
      repeat (12) @(negedge clock);
      reset = 1'b0;

      // End of input at record start, twice.
      send_request(8'($urandom_range(0, 255)), 1'b1);
      send_request(8'($urandom_range(0, 255)), 1'b1);
      // Extreme data bytes, then a stray quote.
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(CH_QUOTE, 1'b0);
      // Quoted field with a delimiter, a CR and a doubled quote, then junk after it.
      send_request(CH_QUOTE, 1'b0);
      send_request(delim_now, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(CH_QUOTE, 1'b0);
      send_request(CH_QUOTE, 1'b0);
      send_request(CH_QUOTE, 1'b0);
      send_request(8'h7A, 1'b0);
      // Unterminated quoted field.
      send_request(CH_QUOTE, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1);
      // Empty quoted field, empty field, CRLF, then an empty line.
      send_request(CH_QUOTE, 1'b0);
      send_request(CH_QUOTE, 1'b0);
      send_request(delim_now, 1'b0);
      send_request(CH_CR, 1'b0);
      send_request(CH_LF, 1'b0);
      send_request(CH_LF, 1'b0);
      // Lone CR, a quoted field left pending at end of input.
      send_request(CH_CR, 1'b0);
      send_request(CH_QUOTE, 1'b0);
      send_request(CH_QUOTE, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1);
      // End of input right after a CR.
      send_request(CH_CR, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         write_delimiter(phase_delims[p]);
         // Hold the receiver off once while requests keep coming, so the block fills.
         if (p == 3) hold_wanted = 1'b1;
         phase_start = requests_sent;
         while (requests_sent - phase_start < RANDOM_ITEMS / PHASES) begin
            if ($urandom_range(0, 7) == 0) begin
               repeat ($urandom_range(1, 4))
                  send_request(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
               send_record();
            end
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* csv_record_tokenizer.f */
+incdir+rtl
rtl/csvtok_pkg.sv
rtl/csvtok_decode.sv
rtl/csv_record_tokenizer.sv
rtl/csvtok_checker.sv
dv/csv_record_tokenizer_checker.sv
dv/csv_record_tokenizer_tb.sv
